// ===== rtl/core/lsse_pkg.sv =====
// shared types and constants for the sparkle engine
package lsse_pkg;
  localparam int STRIP_PIXELS_DEF  = 32;
  localparam int SPARKLE_SLOTS_DEF = 128;

  localparam logic [7:0] BG_RED_RST   = 8'd15;
  localparam logic [7:0] BG_GREEN_RST = 8'd0;
  localparam logic [7:0] BG_BLUE_RST  = 8'd22;
  localparam logic [8:0] RED_GAIN_RST = 9'd174;

  localparam logic [1:0] REG_BG_RED   = 2'd0;
  localparam logic [1:0] REG_BG_GREEN = 2'd1;
  localparam logic [1:0] REG_BG_BLUE  = 2'd2;
  localparam logic [1:0] REG_RED_GAIN = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPAWN,
    ST_FILL,
    ST_READ,
    ST_DRAW,
    ST_EMIT
  } state_t;

  // one slot record, 24+24+3+3+7 bits
  typedef struct packed {
    logic [23:0] center;
    logic [23:0] side;
    logic [2:0]  step;
    logic [2:0]  count;
    logic [6:0]  pos;
  } slot_t;

  // brightness (9 bits) to packed rgb
  function automatic logic [23:0] color_of(input logic [8:0] x, input logic [8:0] gain);
    logic [17:0] prod;
    logic [9:0]  r;
    logic [7:0]  rr, gg, bb;
    prod = x * gain;
    r    = prod[17:8];
    rr   = (r > 10'd255) ? 8'hff : r[7:0];
    bb   = (x > 9'd255) ? 8'hff : x[7:0];
    gg   = (x > 9'd255) ? 8'(x - 9'd255) : 8'd0;
    return {rr, gg, bb};
  endfunction
endpackage

// ===== rtl/core/led_strip_sparkle_engine.sv =====
// sparkle engine top level: configuration registers and sequencer
// usage:
//   input channel (in_valid/in_ready) takes one item per frame tick:
//   enable and random_word. the block then produces STRIP_PIXELS result
//   items on the output channel (out_valid/out_ready), pixel 0 first,
//   last set on the final pixel.
//   steps per item: the spawn unit runs when a spawn is due, then the
//   frame buffer is filled, then the slot walk reads every slot and draws
//   each active sparkle, then the pixels go out as the receiver takes
//   them. the slot walk over the single-port slot memory takes the
//   largest share of an enabled frame; a blanked frame skips it.
//   in_ready is high only while idle; one item is in work at a time.
//   a receiver stall simply holds the current pixel.
//   reset clears slot valid bits, spawn countdown and registers to their
//   defaults; slot memory needs no clearing pass.
//   configuration (cfg_we/cfg_index/cfg_data) is written while idle.
module led_strip_sparkle_engine #(
  parameter int STRIP_PIXELS  = lsse_pkg::STRIP_PIXELS_DEF,
  parameter int SPARKLE_SLOTS = lsse_pkg::SPARKLE_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        enable,
  input  logic [31:0] random_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  pixel_index,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic        last
);
  logic [7:0] bg_red, bg_green, bg_blue;
  logic [8:0] red_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      bg_red   <= lsse_pkg::BG_RED_RST;
      bg_green <= lsse_pkg::BG_GREEN_RST;
      bg_blue  <= lsse_pkg::BG_BLUE_RST;
      red_gain <= lsse_pkg::RED_GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lsse_pkg::REG_BG_RED:   bg_red   <= cfg_data[7:0];
        lsse_pkg::REG_BG_GREEN: bg_green <= cfg_data[7:0];
        lsse_pkg::REG_BG_BLUE:  bg_blue  <= cfg_data[7:0];
        lsse_pkg::REG_RED_GAIN: red_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  lsse_ctrl #(.STRIP_PIXELS(STRIP_PIXELS), .SPARKLE_SLOTS(SPARKLE_SLOTS)) u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .enable, .random_word,
    .bg_red, .bg_green, .bg_blue, .red_gain,
    .out_valid, .out_ready, .pixel_index, .red, .green, .blue, .last
  );
endmodule

// ===== rtl/core/lsse_spawn.sv =====
// reduction of the random word into sparkle parameters by modular folding
module lsse_spawn (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] random_word,
  output logic        done,
  output logic [2:0]  ticks,
  output logic [3:0]  delay,
  output logic [8:0]  bright
);
  // shared fold unit: 512 = 33 mod 479, used on the raw word and again on its result
  logic        busy;
  logic        phase;
  logic [12:0] acc_b;
  logic [4:0]  acc_t;
  logic [3:0]  acc_d;
  logic [1:0]  low_d;
  logic [8:0]  rem_b;
  logic [3:0]  rem_d;
  logic [2:0]  rem_t;
  logic [15:0] fold_src;
  logic [12:0] fold;
  logic [3:0]  dm;

  always_comb begin
    fold_src = busy ? {3'd0, acc_b} : random_word[31:16];
    fold     = 13'({fold_src[15:9], 5'd0}) + 13'(fold_src[15:9]) + 13'(fold_src[8:0]);
    // byte1 = 4q + low, q folded by 4 = 1 mod 3
    if (acc_d >= 4'd9)      dm = acc_d - 4'd9;
    else if (acc_d >= 4'd6) dm = acc_d - 4'd6;
    else if (acc_d >= 4'd3) dm = acc_d - 4'd3;
    else                    dm = acc_d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        acc_b <= fold;
        // 8 = 1 mod 7
        acc_t <= 5'(random_word[7:6]) + 5'(random_word[5:3]) + 5'(random_word[2:0]);
        acc_d <= 4'(random_word[15:14]) + 4'(random_word[13:12]) + 4'(random_word[11:10]);
        low_d <= random_word[9:8];
      end else if (busy) begin
        phase <= 1'b1;
        if (!phase) begin
          acc_b <= fold;
          if (acc_t >= 5'd14)     rem_t <= 3'(acc_t - 5'd14);
          else if (acc_t >= 5'd7) rem_t <= 3'(acc_t - 5'd7);
          else                    rem_t <= acc_t[2:0];
          rem_d <= {dm[1:0], low_d};
        end else begin
          rem_b <= (acc_b >= 13'd479) ? 9'(acc_b - 13'd479) : acc_b[8:0];
          busy  <= 1'b0;
          done  <= 1'b1;
        end
      end
    end
  end

  assign ticks  = rem_t + 3'd1;
  assign delay  = rem_d + 4'd3;
  assign bright = rem_b + 9'd32;
endmodule

// ===== rtl/core/lsse_ctrl.sv =====
// sequencer: spawn, frame fill, slot walk with drawing, pixel emit
module lsse_ctrl #(
  parameter int STRIP_PIXELS  = lsse_pkg::STRIP_PIXELS_DEF,
  parameter int SPARKLE_SLOTS = lsse_pkg::SPARKLE_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        enable,
  input  logic [31:0] random_word,
  input  logic [7:0]  bg_red,
  input  logic [7:0]  bg_green,
  input  logic [7:0]  bg_blue,
  input  logic [8:0]  red_gain,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  pixel_index,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic        last
);
  localparam int SW = (SPARKLE_SLOTS > 1) ? $clog2(SPARKLE_SLOTS) : 1;
  localparam int PW = (STRIP_PIXELS > 1) ? $clog2(STRIP_PIXELS) : 1;
  localparam logic [SW:0] SLOT_END = (SW+1)'(SPARKLE_SLOTS);
  localparam logic [PW:0] PIX_END = (PW+1)'(STRIP_PIXELS);

  lsse_pkg::state_t state, state_next;

  logic [SPARKLE_SLOTS-1:0] active;
  lsse_pkg::slot_t slot_mem [SPARKLE_SLOTS];
  logic [23:0] fb [STRIP_PIXELS];
  logic [7:0]  countdown;
  logic        en_r;
  logic [SW:0] slot_i;
  logic [PW:0] pix_i;
  lsse_pkg::slot_t rd;
  logic [1:0]  sub;

  logic        sp_start, sp_done;
  logic [2:0]  sp_ticks;
  logic [3:0]  sp_delay;
  logic [8:0]  sp_bright;

  lsse_spawn u_spawn (
    .clk, .rst, .start(sp_start), .random_word,
    .done(sp_done), .ticks(sp_ticks), .delay(sp_delay), .bright(sp_bright)
  );

  // first free slot
  logic [SW-1:0] free_i;
  logic          free_ok;
  always_comb begin
    free_i  = '0;
    free_ok = 1'b0;
    for (int k = SPARKLE_SLOTS - 1; k >= 0; k--) begin
      if (!active[k]) begin
        free_i  = SW'(k);
        free_ok = 1'b1;
      end
    end
  end

  logic [9:0]  side_sum;
  logic [23:0] bg;
  logic [7:0]  draw_pos;
  logic [23:0] draw_col;
  lsse_pkg::slot_t stepped;
  logic        retire;
  assign side_sum = {1'b0, sp_bright} + {2'b0, bg_blue};
  assign bg = {bg_red, bg_green, bg_blue};
  assign draw_pos = {1'b0, rd.pos} + {6'b0, sub} - 8'd1;
  assign draw_col = (sub == 2'd1) ? rd.center : rd.side;

  always_comb begin
    stepped = rd;
    retire  = 1'b0;
    stepped.count = rd.count - 3'd1;
    if (stepped.count == 3'd0) begin
      stepped.pos   = rd.pos + 7'd1;
      stepped.count = rd.step;
      retire        = (stepped.pos > 7'(STRIP_PIXELS));
    end
  end

  always_comb begin
    state_next = state;
    sp_start   = 1'b0;
    in_ready   = (state == lsse_pkg::ST_IDLE);
    case (state)
      lsse_pkg::ST_IDLE:
        if (in_valid) begin
          if (enable && countdown == 8'd0) begin
            sp_start   = 1'b1;
            state_next = lsse_pkg::ST_SPAWN;
          end else begin
            state_next = lsse_pkg::ST_FILL;
          end
        end
      lsse_pkg::ST_SPAWN:
        if (sp_done) state_next = lsse_pkg::ST_FILL;
      lsse_pkg::ST_FILL:
        if (pix_i == PIX_END - 1'b1)
          state_next = en_r ? lsse_pkg::ST_READ : lsse_pkg::ST_EMIT;
      lsse_pkg::ST_READ:
        if (slot_i == SLOT_END) state_next = lsse_pkg::ST_EMIT;
        else if (active[slot_i[SW-1:0]]) state_next = lsse_pkg::ST_DRAW;
      lsse_pkg::ST_DRAW:
        if (sub == 2'd2) state_next = lsse_pkg::ST_READ;
      lsse_pkg::ST_EMIT:
        if (out_ready && out_valid && last) state_next = lsse_pkg::ST_IDLE;
      default: state_next = lsse_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= lsse_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // memories and datapath
  always_ff @(posedge clk) begin
    if (state == lsse_pkg::ST_SPAWN && sp_done && free_ok) begin
      slot_mem[free_i] <= '{center: lsse_pkg::color_of(sp_bright, red_gain),
                            side:   lsse_pkg::color_of(side_sum[9:1], red_gain),
                            step: sp_ticks, count: sp_ticks, pos: 7'd0};
    end else if (state == lsse_pkg::ST_DRAW && sub == 2'd2) begin
      slot_mem[slot_i[SW-1:0]] <= stepped;
    end
    if (state == lsse_pkg::ST_READ && slot_i != SLOT_END)
      rd <= slot_mem[slot_i[SW-1:0]];
    if (state == lsse_pkg::ST_FILL)
      fb[pix_i[PW-1:0]] <= en_r ? bg : 24'd0;
    else if (state == lsse_pkg::ST_DRAW && draw_pos < 8'(STRIP_PIXELS))
      fb[draw_pos[PW-1:0]] <= draw_col;
  end

  logic [23:0] pix_col;
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= '0;
      countdown <= '0;
      en_r      <= 1'b0;
      slot_i    <= '0;
      pix_i     <= '0;
      sub       <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        lsse_pkg::ST_IDLE: begin
          pix_i  <= '0;
          slot_i <= '0;
          if (in_valid) en_r <= enable;
        end
        lsse_pkg::ST_SPAWN:
          if (sp_done) begin
            if (free_ok) active[free_i] <= 1'b1;
            countdown <= {4'd0, sp_delay};
          end
        lsse_pkg::ST_FILL: begin
          pix_i <= (pix_i == PIX_END - 1'b1) ? '0 : pix_i + 1'b1;
          if (pix_i == PIX_END - 1'b1 && en_r) countdown <= countdown - 8'd1;
        end
        lsse_pkg::ST_READ: begin
          sub <= '0;
          if (slot_i != SLOT_END && !active[slot_i[SW-1:0]]) slot_i <= slot_i + 1'b1;
        end
        lsse_pkg::ST_DRAW: begin
          sub <= sub + 2'd1;
          if (sub == 2'd2) begin
            if (retire) active[slot_i[SW-1:0]] <= 1'b0;
            slot_i <= slot_i + 1'b1;
          end
        end
        lsse_pkg::ST_EMIT: begin
          if (!out_valid || out_ready) begin
            if (out_valid && last) begin
              out_valid <= 1'b0;
            end else begin
              out_valid   <= 1'b1;
              pixel_index <= 6'(pix_i);
              last        <= (pix_i == PIX_END - 1'b1);
              pix_i       <= pix_i + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == lsse_pkg::ST_EMIT && (!out_valid || out_ready) && pix_i < PIX_END)
      pix_col <= fb[pix_i[PW-1:0]];
  end
  assign red   = pix_col[23:16];
  assign green = pix_col[15:8];
  assign blue  = pix_col[7:0];

  a_out_only_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == lsse_pkg::ST_EMIT) else $error("result outside emit");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while emitting");
  a_last_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> state == lsse_pkg::ST_IDLE)
    else $error("frame did not close");
endmodule

// ===== test/testbench.sv =====
// testbench for the sparkle engine: queue-fed driver, checking monitor, frame predictor
`timescale 1ns / 1ps

module testbench;
  localparam int PIXELS = lsse_pkg::STRIP_PIXELS_DEF;
  localparam int SLOTS = lsse_pkg::SPARKLE_SLOTS_DEF;
  localparam int IDLE_LIMIT = 6000;

  typedef struct {
    logic        en;
    logic [31:0] rnd;
    bit          drain;  // hold this item back until every pixel is out
  } tick_t;

  typedef struct {
    logic [5:0] idx;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       lst;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = lsse_pkg::REG_BG_RED;
  logic [8:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        enable = 1'b0;
  logic [31:0] random_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  pixel_index;
  logic [7:0]  red, green, blue;
  logic        last;

  led_strip_sparkle_engine i_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .enable(enable), .random_word(random_word),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_index(pixel_index), .red(red), .green(green), .blue(blue), .last(last)
  );

  always #2ns clk = ~clk;

  // predictor copy of registers and sparkle pool
  logic [7:0]  m_bg_r = lsse_pkg::BG_RED_RST, m_bg_g = lsse_pkg::BG_GREEN_RST;
  logic [7:0]  m_bg_b = lsse_pkg::BG_BLUE_RST;
  logic [8:0]  m_gain = lsse_pkg::RED_GAIN_RST;
  logic [23:0] pool_center [SLOTS];
  logic [23:0] pool_side [SLOTS];
  logic [2:0]  pool_step [SLOTS];
  logic [2:0]  pool_count [SLOTS];
  logic [6:0]  pool_pos [SLOTS];
  bit          pool_live [SLOTS];
  logic [7:0]  countdown = '0;

  tick_t  pending_ticks[$];
  pixel_t expected_pixels[$];
  int     mismatches = 0;
  int     idle_cycles = 0;

  function automatic logic [23:0] brightness_rgb(int x);
    int r, g, b;
    b = x > 255 ? 255 : x;
    r = (x * m_gain) >> 8;
    if (r > 255) r = 255;
    g = x > 255 ? (x - 255 > 255 ? 255 : x - 255) : 0;
    return {r[7:0], g[7:0], b[7:0]};
  endfunction

  task automatic predict_frame(logic en, logic [31:0] rnd);
    logic [23:0] frame [PIXELS];
    int bright, p;
    pixel_t px;
    for (int i = 0; i < PIXELS; i++) frame[i] = '0;
    if (en) begin
      for (int i = 0; i < PIXELS; i++) frame[i] = {m_bg_r, m_bg_g, m_bg_b};
      if (countdown == 0) begin
        bright = rnd[31:16] % 479 + 32;
        for (int s = 0; s < SLOTS; s++) begin
          if (!pool_live[s]) begin
            pool_center[s] = brightness_rgb(bright);
            pool_side[s] = brightness_rgb((bright + m_bg_b) >> 1);
            pool_step[s] = 3'(rnd[7:0] % 7 + 1);
            pool_count[s] = 3'(rnd[7:0] % 7 + 1);
            pool_pos[s] = '0;
            pool_live[s] = 1'b1;
            break;
          end
        end
        countdown = 8'(rnd[15:8] % 12 + 3);
      end
      for (int s = 0; s < SLOTS; s++) begin
        if (pool_live[s]) begin
          p = int'(pool_pos[s]);
          if (p - 1 >= 0 && p - 1 < PIXELS) frame[p - 1] = pool_side[s];
          if (p < PIXELS) frame[p] = pool_center[s];
          if (p + 1 < PIXELS) frame[p + 1] = pool_side[s];
          pool_count[s] = pool_count[s] - 3'd1;
          if (pool_count[s] == 0) begin
            pool_pos[s] = pool_pos[s] + 7'd1;
            pool_count[s] = pool_step[s];
            if (pool_pos[s] > PIXELS) pool_live[s] = 1'b0;
          end
        end
      end
      countdown = countdown - 8'd1;
    end
    for (int i = 0; i < PIXELS; i++) begin
      px.idx = i[5:0];
      {px.r, px.g, px.b} = frame[i];
      px.lst = (i == PIXELS - 1);
      expected_pixels.push_back(px);
    end
  endtask

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    logic  v_next;
    tick_t t;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      v_next = in_valid;
      if (in_valid && in_ready) begin
        predict_frame(enable, random_word);
        v_next = 1'b0;
        in_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      end
      if (!v_next) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_ticks.size() > 0 &&
                     (!pending_ticks[0].drain || expected_pixels.size() == 0)) begin
          t = pending_ticks.pop_front();
          enable <= t.en;
          random_word <= t.rnd;
          v_next = 1'b1;
        end
      end
      in_valid <= v_next;
    end
  end

  // monitor
  int out_gap = 0;
  int pixels_seen = 0;
  int long_hold = 0;
  always @(posedge clk) begin
    logic   r_next;
    pixel_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      r_next = out_ready;
      if (out_valid && out_ready) begin
        pixels_seen++;
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected pixel idx=%0d", pixel_index);
        end else begin
          e = expected_pixels.pop_front();
          if (e.idx !== pixel_index || e.r !== red || e.g !== green || e.b !== blue ||
              e.lst !== last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pixel mismatch: exp idx=%0d rgb=%h %h %h last=%b, got idx=%0d rgb=%h %h %h last=%b",
                       e.idx, e.r, e.g, e.b, e.lst, pixel_index, red, green, blue, last);
          end
        end
        r_next = 1'b0;
        out_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
        // one long receiver stall while the sender keeps offering
        if (pixels_seen == 800) long_hold = 400;
      end
      if (!r_next) begin
        if (long_hold > 0) long_hold--;
        else if (out_gap > 0) out_gap--;
        else r_next = 1'b1;
      end
      out_ready <= r_next;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // sampled away from the rising edge so the driver's updates have settled
  task automatic wait_idle();
    while (pending_ticks.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(negedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      lsse_pkg::REG_BG_RED:   m_bg_r = val[7:0];
      lsse_pkg::REG_BG_GREEN: m_bg_g = val[7:0];
      lsse_pkg::REG_BG_BLUE:  m_bg_b = val[7:0];
      lsse_pkg::REG_RED_GAIN: m_gain = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_tick(logic en, logic [31:0] rnd, bit drain);
    tick_t t;
    t.en = en;
    t.rnd = rnd;
    t.drain = drain;
    pending_ticks.push_back(t);
  endtask

  task automatic add_random(int n);
    for (int i = 0; i < n; i++)
      add_tick($urandom_range(0, 9) != 0, $urandom, $urandom_range(0, 39) == 0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes of ticks, delay and brightness, blanked frames
    add_tick(1'b0, 32'hffff_ffff, 1'b0);
    add_tick(1'b1, 32'h0000_0000, 1'b0);
    add_tick(1'b1, 32'hffff_ffff, 1'b0);
    add_tick(1'b1, 32'h01de_0b06, 1'b0);
    add_tick(1'b1, 32'h01df_0c07, 1'b0);
    add_tick(1'b0, 32'h0000_0000, 1'b0);
    add_tick(1'b1, 32'h00e0_ff00, 1'b1);
    for (int i = 0; i < 12; i++) add_tick(1'b1, {16'h01de, 8'h00, 8'h00}, 1'b0);
    add_tick(1'b1, 32'hffff_ffff, 1'b1);
    add_random(60);
    wait_idle();

    write_reg(lsse_pkg::REG_BG_RED, 9'h000);
    write_reg(lsse_pkg::REG_BG_GREEN, 9'h000);
    write_reg(lsse_pkg::REG_BG_BLUE, 9'h000);
    write_reg(lsse_pkg::REG_RED_GAIN, 9'h000);
    add_random(60);
    wait_idle();

    write_reg(lsse_pkg::REG_BG_RED, 9'h1ff);
    write_reg(lsse_pkg::REG_BG_GREEN, 9'h0ff);
    write_reg(lsse_pkg::REG_BG_BLUE, 9'h1ff);
    write_reg(lsse_pkg::REG_RED_GAIN, 9'h1ff);
    add_random(60);
    wait_idle();

    write_reg(lsse_pkg::REG_BG_RED, 9'($urandom));
    write_reg(lsse_pkg::REG_BG_GREEN, 9'($urandom));
    write_reg(lsse_pkg::REG_BG_BLUE, 9'($urandom));
    write_reg(lsse_pkg::REG_RED_GAIN, 9'($urandom));
    add_random(100);
    wait_idle();

    repeat (100) @(posedge clk);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
